// File: hdl/sktrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sktrq_pkg
// shared constants, codes and beat types for the sorted key table
// ----------------------------------------------------------------------------
package sktrq_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 32;
  localparam int TAG_BITS = 16;
  localparam int RANK_W   = 6;
  localparam int CL_W     = 8;
  localparam int CE_W     = 7;

  // count of stored entries, can hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);
  // width for rank against count/index compares
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // reduction tree geometry
  localparam int GROUP  = 8;
  localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;
  localparam int PAD    = NGROUP * GROUP;
  localparam int GCNT_W = $clog2(GROUP + 1);

  // count_less when the query key is below every stored key
  localparam logic signed [CL_W-1:0] CL_BELOW = CL_W'(-1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } st_e_t;

  typedef struct packed {
    op_e_t                       opcode;
    logic signed [KEY_BITS-1:0]  key;
    logic        [TAG_BITS-1:0]  tag;
    logic        [RANK_W-1:0]    rank;
  } in_item_t;

  typedef struct packed {
    st_e_t                       status;
    logic signed [CL_W-1:0]      count_less;
    logic        [CE_W-1:0]      count_equal;
    logic signed [KEY_BITS-1:0]  entry_key;
    logic        [TAG_BITS-1:0]  entry_tag;
  } out_result_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                        ins_en;
    logic                        rd_en;
    logic signed [KEY_BITS-1:0]  key;
    logic        [TAG_BITS-1:0]  tag;
    logic        [RANK_W-1:0]    rank;
    logic        [CNT_W-1:0]     count;
  } cell_ctl_t;

  // registered compare flags and gated read data from one cell
  typedef struct packed {
    logic                        lt;
    logic                        eq;
    logic signed [KEY_BITS-1:0]  key;
    logic        [TAG_BITS-1:0]  tag;
  } cell_tap_t;

endpackage
`default_nettype wire

// File: hdl/sktrq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sktrq_cell
// one table slot: holds a key and tag, compares against the broadcast key
// and takes its left neighbor's entry when an insert lands below it
// ----------------------------------------------------------------------------
module sktrq_cell (
  input  wire logic                              clk,
  input  wire logic [sktrq_pkg::CNT_W-1:0]       cell_idx,
  input  wire sktrq_pkg::cell_ctl_t              ctl,
  input  wire logic                              prev_shift,
  input  wire logic signed [sktrq_pkg::KEY_BITS-1:0] prev_key,
  input  wire logic [sktrq_pkg::TAG_BITS-1:0]    prev_tag,
  output logic                                   shift,
  output logic signed [sktrq_pkg::KEY_BITS-1:0]  key,
  output logic [sktrq_pkg::TAG_BITS-1:0]         tag,
  output sktrq_pkg::cell_tap_t                   tap
);

  logic signed [sktrq_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [sktrq_pkg::TAG_BITS-1:0]        tag_r, tag_nxt;
  sktrq_pkg::cell_tap_t                  tap_r, tap_nxt;
  logic                                  occ;
  logic                                  at_end;
  logic                                  load;
  logic                                  sel;

  always_comb begin
    occ    = ctl.count > cell_idx;
    at_end = ctl.count == cell_idx;
    // strictly greater: equal keys stay ahead, so ties keep arrival order
    shift  = occ && ($signed(key_r) > $signed(ctl.key));
    load   = ctl.ins_en && (shift || at_end);
    if (prev_shift) begin
      key_nxt = prev_key;
      tag_nxt = prev_tag;
    end else begin
      key_nxt = ctl.key;
      tag_nxt = ctl.tag;
    end

    sel = ctl.rd_en && occ &&
          (sktrq_pkg::CMP_W'(cell_idx) == sktrq_pkg::CMP_W'(ctl.rank));
    tap_nxt.lt  = occ && ($signed(key_r) < $signed(ctl.key));
    tap_nxt.eq  = occ && (key_r == ctl.key);
    tap_nxt.key = sel ? key_r : '0;
    tap_nxt.tag = sel ? tag_r : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key_nxt;
      tag_r <= tag_nxt;
    end
    tap_r <= tap_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;
  assign tap = tap_r;

endmodule
`default_nettype wire

// File: hdl/sktrq_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sktrq_reduce
// two level tree over the cell taps: registered per-group counts and
// or of read data, then a sum across the groups
// ----------------------------------------------------------------------------
module sktrq_reduce (
  input  wire logic                              clk,
  input  wire sktrq_pkg::cell_tap_t              tap [sktrq_pkg::DEPTH],
  output logic [sktrq_pkg::CNT_W-1:0]            less,
  output logic [sktrq_pkg::CNT_W-1:0]            equal,
  output logic signed [sktrq_pkg::KEY_BITS-1:0]  rd_key,
  output logic [sktrq_pkg::TAG_BITS-1:0]         rd_tag
);

  sktrq_pkg::cell_tap_t tap_p [sktrq_pkg::PAD];

  logic [sktrq_pkg::GCNT_W-1:0]          gl_r   [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::GCNT_W-1:0]          gl_nxt [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::GCNT_W-1:0]          ge_r   [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::GCNT_W-1:0]          ge_nxt [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::KEY_BITS-1:0]        gk_r   [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::KEY_BITS-1:0]        gk_nxt [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::TAG_BITS-1:0]        gt_r   [sktrq_pkg::NGROUP];
  logic [sktrq_pkg::TAG_BITS-1:0]        gt_nxt [sktrq_pkg::NGROUP];

  // pad the tap row up to a whole number of groups
  for (genvar i = 0; i < sktrq_pkg::PAD; i++) begin : g_pad
    if (i < sktrq_pkg::DEPTH) begin : g_live
      assign tap_p[i] = tap[i];
    end else begin : g_zero
      assign tap_p[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < sktrq_pkg::NGROUP; g++) begin
      gl_nxt[g] = '0;
      ge_nxt[g] = '0;
      gk_nxt[g] = '0;
      gt_nxt[g] = '0;
      for (int j = 0; j < sktrq_pkg::GROUP; j++) begin
        gl_nxt[g] = gl_nxt[g] + sktrq_pkg::GCNT_W'(tap_p[g*sktrq_pkg::GROUP+j].lt);
        ge_nxt[g] = ge_nxt[g] + sktrq_pkg::GCNT_W'(tap_p[g*sktrq_pkg::GROUP+j].eq);
        gk_nxt[g] = gk_nxt[g] | tap_p[g*sktrq_pkg::GROUP+j].key;
        gt_nxt[g] = gt_nxt[g] | tap_p[g*sktrq_pkg::GROUP+j].tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    gl_r <= gl_nxt;
    ge_r <= ge_nxt;
    gk_r <= gk_nxt;
    gt_r <= gt_nxt;
  end

  always_comb begin
    less   = '0;
    equal  = '0;
    rd_key = '0;
    rd_tag = '0;
    for (int g = 0; g < sktrq_pkg::NGROUP; g++) begin
      less   = less  + sktrq_pkg::CNT_W'(gl_r[g]);
      equal  = equal + sktrq_pkg::CNT_W'(ge_r[g]);
      rd_key = rd_key | gk_r[g];
      rd_tag = rd_tag | gt_r[g];
    end
  end

endmodule
`default_nettype wire

// File: hdl/sorted_key_table_rank_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_rank_query
// sorted (key, tag) table built as a row of cells, with clear, sorted
// insert, rank query and read by rank
// ----------------------------------------------------------------------------
// pipeline: the result strobe rises with the output register, after the
//   cell compare, group count register and final sum into output register
// busy: high while an accepted item is in the pipeline, low again during
//   the result beat; start is not accepted while busy is high
// reset: clears the entry count, pipeline and strobe; cell contents are not
//   cleared and read as an empty table; the receiver cannot stall, each
//   result beat is shown for exactly one cycle
// ----------------------------------------------------------------------------
module sorted_key_table_rank_query (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire sktrq_pkg::in_item_t    in_item,
  output logic                        out_strobe,
  output sktrq_pkg::out_result_t      out_result
);

  // accepted item and pipeline valids
  sktrq_pkg::in_item_t          item_r;
  logic                         v0_r, v1_r, v2_r;
  logic                         out_strobe_r;
  sktrq_pkg::out_result_t       out_result_r, out_result_nxt;

  // number of stored entries
  logic [sktrq_pkg::CNT_W-1:0]  count_r, count_nxt;

  // status and opcode travel beside the tap and group stages
  sktrq_pkg::st_e_t             st0;
  sktrq_pkg::st_e_t             st1_r, st2_r;
  sktrq_pkg::op_e_t             op1_r, op2_r;

  logic                         accept;
  logic                         full;
  logic                         empty;

  sktrq_pkg::cell_ctl_t         ctl;

  // neighbor links along the cell row
  logic                                  shift_w [sktrq_pkg::DEPTH];
  logic signed [sktrq_pkg::KEY_BITS-1:0] key_w   [sktrq_pkg::DEPTH];
  logic [sktrq_pkg::TAG_BITS-1:0]        tag_w   [sktrq_pkg::DEPTH];
  sktrq_pkg::cell_tap_t                  tap_w   [sktrq_pkg::DEPTH];

  logic [sktrq_pkg::CNT_W-1:0]           less, equal;
  logic signed [sktrq_pkg::KEY_BITS-1:0] rd_key;
  logic [sktrq_pkg::TAG_BITS-1:0]        rd_tag;
  logic [sktrq_pkg::CNT_W+sktrq_pkg::CL_W-1:0] less_ext;
  logic [sktrq_pkg::CNT_W+sktrq_pkg::CE_W-1:0] equal_ext;

  assign busy   = v0_r | v1_r | v2_r;
  assign accept = start & ~busy;
  assign full   = count_r == sktrq_pkg::CNT_W'(sktrq_pkg::DEPTH);
  assign empty  = count_r == '0;

  // status and count update for the item in the compare stage
  always_comb begin
    st0       = sktrq_pkg::ST_OK;
    count_nxt = count_r;
    unique case (item_r.opcode)
      sktrq_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      sktrq_pkg::OP_INSERT: begin
        if (full) begin
          st0 = sktrq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + sktrq_pkg::CNT_W'(1);
        end
      end
      sktrq_pkg::OP_QUERY: begin
        if (empty) begin
          st0 = sktrq_pkg::ST_EMPTY;
        end
      end
      sktrq_pkg::OP_READ: begin
        if (empty) begin
          st0 = sktrq_pkg::ST_EMPTY;
        end else if (sktrq_pkg::CMP_W'(item_r.rank) >= sktrq_pkg::CMP_W'(count_r)) begin
          st0 = sktrq_pkg::ST_RANGE;
        end
      end
      default: begin
        st0 = sktrq_pkg::ST_OK;
      end
    endcase
  end

  // broadcast to the cells; taps sample the count before this item's update
  always_comb begin
    ctl.ins_en = v0_r && (item_r.opcode == sktrq_pkg::OP_INSERT) && !full;
    ctl.rd_en  = v0_r && (item_r.opcode == sktrq_pkg::OP_READ);
    ctl.key    = item_r.key;
    ctl.tag    = item_r.tag;
    ctl.rank   = item_r.rank;
    ctl.count  = count_r;
  end

  // the cell row: cell i takes cell i-1's entry when cell i-1 sits above the new key
  for (genvar i = 0; i < sktrq_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sktrq_cell u_cell (
        .clk        (clk),
        .cell_idx   (sktrq_pkg::CNT_W'(i)),
        .ctl        (ctl),
        .prev_shift (1'b0),
        .prev_key   ('0),
        .prev_tag   ('0),
        .shift      (shift_w[i]),
        .key        (key_w[i]),
        .tag        (tag_w[i]),
        .tap        (tap_w[i])
      );
    end else begin : g_body
      sktrq_cell u_cell (
        .clk        (clk),
        .cell_idx   (sktrq_pkg::CNT_W'(i)),
        .ctl        (ctl),
        .prev_shift (shift_w[i-1]),
        .prev_key   (key_w[i-1]),
        .prev_tag   (tag_w[i-1]),
        .shift      (shift_w[i]),
        .key        (key_w[i]),
        .tag        (tag_w[i]),
        .tap        (tap_w[i])
      );
    end
  end

  // count and gather the cell taps
  sktrq_reduce u_reduce (
    .clk    (clk),
    .tap    (tap_w),
    .less   (less),
    .equal  (equal),
    .rd_key (rd_key),
    .rd_tag (rd_tag)
  );

  // result assembly: fields without meaning for the opcode stay zero
  always_comb begin
    less_ext  = {{sktrq_pkg::CL_W{1'b0}}, less};
    equal_ext = {{sktrq_pkg::CE_W{1'b0}}, equal};
    out_result_nxt             = '0;
    out_result_nxt.status      = st2_r;
    if (st2_r == sktrq_pkg::ST_OK) begin
      if (op2_r == sktrq_pkg::OP_QUERY) begin
        // no smaller and no equal key means the query is below every key
        if (less == '0 && equal == '0) begin
          out_result_nxt.count_less = sktrq_pkg::CL_BELOW;
        end else begin
          out_result_nxt.count_less = less_ext[sktrq_pkg::CL_W-1:0];
        end
        out_result_nxt.count_equal = equal_ext[sktrq_pkg::CE_W-1:0];
      end
      if (op2_r == sktrq_pkg::OP_READ) begin
        out_result_nxt.entry_key = rd_key;
        out_result_nxt.entry_tag = rd_tag;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_strobe_r <= 1'b0;
      count_r      <= '0;
    end else begin
      v0_r         <= accept;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      out_strobe_r <= v2_r;
      if (v0_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    st1_r <= st0;
    op1_r <= item_r.opcode;
    st2_r <= st1_r;
    op2_r <= op1_r;
    if (v2_r) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

// File: hdl/sktrq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sktrq_checker
// port level checks on the sorted key table, bound to the top level
// ----------------------------------------------------------------------------
module sktrq_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_strobe,
  input wire sktrq_pkg::out_result_t out_result
);

  logic acc;
  assign acc = start & ~busy;

  // an accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy)
    else $error("busy not raised after accept");

  // every accepted item gives its result beat a fixed time later
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##4 out_strobe)
    else $error("result beat missing after accept");

  // the result beat closes the item, so the block is free again
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy during result beat");

  // a flagged result carries no counts and no entry
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status != sktrq_pkg::ST_OK) |->
      (out_result.count_less == '0 && out_result.count_equal == '0 &&
       out_result.entry_key == '0 && out_result.entry_tag == '0))
    else $error("flagged result with nonzero fields");

endmodule

bind sorted_key_table_rank_query sktrq_checker u_sktrq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
`default_nettype wire
